@@ rtl/tasps_pkg.sv @@
// ----------------------------------------------------------------------------
// tasps_pkg: shared types and constants
// Action codes, register indexes and field widths for the step scheduler.
// ----------------------------------------------------------------------------
package tasps_pkg;
   localparam int unsigned DUR_W   = 16;
   localparam int unsigned RATE_W  = 16;
   localparam int unsigned SCALE_W = 9;
   localparam int unsigned DELTA_W = 13;
   localparam int unsigned MAG_W   = 12 + 1;
   localparam int unsigned DIVR_W  = MAG_W + SCALE_W;  // 22 bits
   localparam int unsigned TICK_W  = 32;
   localparam int unsigned CSR_IDX_W = 1;
   localparam int unsigned IN_AXES = 3;

   typedef enum logic [1:0] {
      ACT_NONE = 2'd0,
      ACT_CW   = 2'd1,
      ACT_CCW  = 2'd2
   } action_type;

   localparam logic [CSR_IDX_W-1:0] CSR_TICK_RATE  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_SCALE = 1'd1;

   typedef struct packed {
      logic              start;
      logic [TICK_W-1:0] dividend;
      logic [DIVR_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [TICK_W-1:0] quotient;
   } div_rsp_type;
endpackage

@@ rtl/tasps_if.sv @@
// ----------------------------------------------------------------------------
// tasps channel interfaces
// Valid/ready channels for request, response and register writes.
// ----------------------------------------------------------------------------
interface tasps_req_if;
   logic                                valid;
   logic                                ready;
   logic                                mode;
   logic        [tasps_pkg::DUR_W-1:0]  duration;
   logic signed [tasps_pkg::DELTA_W-1:0] delta_x;
   logic signed [tasps_pkg::DELTA_W-1:0] delta_y;
   logic signed [tasps_pkg::DELTA_W-1:0] delta_z;
   modport source (output valid, mode, duration, delta_x, delta_y, delta_z, input ready);
   modport sink   (input valid, mode, duration, delta_x, delta_y, delta_z, output ready);
endinterface

interface tasps_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] action_x;
   logic [1:0] action_y;
   logic [1:0] action_z;
   logic       moving;
   logic       move_done;
   modport source (output valid, action_x, action_y, action_z, moving, move_done,
                   input ready);
   modport sink   (input valid, action_x, action_y, action_z, moving, move_done,
                   output ready);
endinterface

interface tasps_csr_if;
   logic                                 valid;
   logic                                 ready;
   logic [tasps_pkg::CSR_IDX_W-1:0]      index;
   logic [tasps_pkg::RATE_W-1:0]         data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/tasps_div.sv @@
// ----------------------------------------------------------------------------
// tasps_div: restoring divider
// One quotient bit per cycle; a division runs through all 32 dividend bits.
// ----------------------------------------------------------------------------
module tasps_div (
   input  logic                   clock,
   input  logic                   reset,
   input  tasps_pkg::div_req_type req,
   output tasps_pkg::div_rsp_type rsp
);
   import tasps_pkg::*;

   localparam int unsigned CNT_W = $clog2(TICK_W + 1);

   logic [TICK_W-1:0] quo_ff, quo_in;
   logic [DIVR_W:0]   rem_ff, rem_in;
   logic [DIVR_W-1:0] dvs_ff, dvs_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DIVR_W:0]   trial;
   logic [DIVR_W+1:0] diff;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[DIVR_W-1:0], quo_ff[TICK_W-1]};
      diff    = {1'b0, trial} - {2'b00, dvs_ff};
      if (req.start) begin
         quo_in  = req.dividend;
         rem_in  = '0;
         dvs_in  = req.divisor;
         cnt_in  = CNT_W'(TICK_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[DIVR_W+1]) begin
            rem_in = diff[DIVR_W:0];
            quo_in = {quo_ff[TICK_W-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[TICK_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;
endmodule

@@ rtl/tasps_lane.sv @@
// ----------------------------------------------------------------------------
// tasps_lane: one axis
// Holds interval, direction and active flag; a phase counter marks multiples.
// ----------------------------------------------------------------------------
module tasps_lane (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          load,
   input  logic                          load_dir,
   input  logic                          load_active,
   input  logic                          set_int,
   input  logic [tasps_pkg::TICK_W-1:0]  int_val,
   input  logic                          tick,
   output tasps_pkg::action_type         action
);
   import tasps_pkg::*;

   logic [TICK_W-1:0] int_ff, int_in;
   logic [TICK_W-1:0] phase_ff, phase_in;
   logic              dir_ff, act_ff;

   always_comb begin
      int_in   = int_ff;
      phase_in = phase_ff;
      if (set_int)
         int_in = (int_val == '0) ? TICK_W'(1) : int_val;
      if (load)
         phase_in = '0;
      else if (tick)
         phase_in = (phase_ff + 1'b1 == int_ff) ? '0 : phase_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         int_ff   <= TICK_W'(1);
         phase_ff <= '0;
         dir_ff   <= 1'b0;
         act_ff   <= 1'b0;
      end else begin
         int_ff   <= int_in;
         phase_ff <= phase_in;
         if (load) begin
            dir_ff <= load_dir;
            act_ff <= load_active;
         end
      end
   end

   always_comb begin
      action = ACT_NONE;
      if (act_ff && phase_ff == '0)
         action = dir_ff ? ACT_CCW : ACT_CW;
   end
endmodule

@@ rtl/three_axis_step_pulse_scheduler_top.sv @@
// ----------------------------------------------------------------------------
// three_axis_step_pulse_scheduler_top
// Loads a move, then reports per-axis step actions on each tick beat.
// ----------------------------------------------------------------------------
// A tick beat passes through ST_RESP to its response. A load beat computes
// total ticks with one 16x16 multiply in ST_MUL, then runs one shared
// restoring divider per active axis: a moving axis spends ST_DIVST forming
// the divisor and starting, then ST_DIVWT waiting for the divider; a still
// axis only passes through ST_DIVST. The load then responds via ST_RESP.
// One beat is processed at a time; a response register holds the result
// until it is taken.
module three_axis_step_pulse_scheduler_top #(
   parameter int unsigned AXES = 3
) (
   input  logic       clock,
   input  logic       reset,
   tasps_req_if.sink  req,
   tasps_rsp_if.source rsp,
   tasps_csr_if.sink  csr
);
   import tasps_pkg::*;

   localparam int unsigned AX_W = (AXES > 1) ? $clog2(AXES) : 1;

   typedef enum logic [2:0] {
      ST_IDLE, ST_MUL, ST_DIVST, ST_DIVWT, ST_RESP
   } state_type;

   state_type state_ff;
   logic [RATE_W-1:0]  rate_ff;
   logic [SCALE_W-1:0] scale_ff;
   logic [TICK_W-1:0]  total_ff, count_ff;
   logic               busy_ff;
   logic [DUR_W-1:0]   dur_ff;
   logic [MAG_W-1:0]   mag_ff [AXES];
   logic [AX_W-1:0]    ax_ff;
   logic [DIVR_W-1:0]  divr_ff;
   logic [1:0]         act_ff [IN_AXES];
   logic               moving_ff, done_ff, rvalid_ff;

   div_req_type dreq;
   div_rsp_type drsp;
   action_type  lane_act [AXES];
   logic        load_p, tick_p;
   logic [AXES-1:0] set_p;
   logic [SCALE_W-1:0] scale_eff;
   logic [DELTA_W-1:0] din [IN_AXES];
   logic [TICK_W-1:0] count_nx;

   assign req.ready = (state_ff == ST_IDLE) && !rvalid_ff;
   assign csr.ready = 1'b1;
   assign din[0] = req.delta_x;
   assign din[1] = req.delta_y;
   assign din[2] = req.delta_z;
   assign scale_eff = (scale_ff == '0) ? SCALE_W'(1) : scale_ff;
   assign load_p = req.valid && req.ready && !req.mode;
   assign tick_p = req.valid && req.ready && req.mode && busy_ff;
   assign count_nx = count_ff + 1'b1;

   assign dreq.start    = (state_ff == ST_DIVST);
   assign dreq.dividend = total_ff;
   assign dreq.divisor  = divr_ff;

   tasps_div u_div (.clock(clock), .reset(reset), .req(dreq), .rsp(drsp));

   for (genvar g = 0; g < AXES; g++) begin : g_lane
      assign set_p[g] = (state_ff == ST_DIVWT) && drsp.done && (ax_ff == AX_W'(g));
      tasps_lane u_lane (
         .clock(clock), .reset(reset), .load(load_p),
         .load_dir(g < IN_AXES ? din[g % IN_AXES][DELTA_W-1] : 1'b0),
         .load_active(g < IN_AXES ? (din[g % IN_AXES] != '0) : 1'b0),
         .set_int(set_p[g] || (load_p && (g >= IN_AXES || din[g % IN_AXES] == '0))),
         .int_val(set_p[g] ? drsp.quotient : TICK_W'(1)),
         .tick(tick_p), .action(lane_act[g]));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff   <= RATE_W'(1000);
         scale_ff  <= SCALE_W'(16);
         state_ff  <= ST_IDLE;
         busy_ff   <= 1'b0;
         total_ff  <= '0;
         count_ff  <= '0;
         rvalid_ff <= 1'b0;
         moving_ff <= 1'b0;
         done_ff   <= 1'b0;
         ax_ff     <= '0;
         divr_ff   <= '0;
      end else begin
         if (csr.valid && csr.ready) begin
            if (csr.index == CSR_TICK_RATE)  rate_ff  <= csr.data;
            if (csr.index == CSR_STEP_SCALE) scale_ff <= csr.data[SCALE_W-1:0];
         end
         if (rvalid_ff && rsp.ready) rvalid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (req.valid && req.ready) begin
                  if (!req.mode) begin
                     for (int i = 0; i < IN_AXES; i++) act_ff[i] <= ACT_NONE;
                     done_ff <= 1'b0;
                     dur_ff <= req.duration;
                     count_ff <= '0;
                     for (int i = 0; i < AXES; i++) begin
                        mag_ff[i] <= (i >= IN_AXES) ? '0 :
                           din[i % IN_AXES][DELTA_W-1] ? MAG_W'(-din[i % IN_AXES]) :
                           MAG_W'(din[i % IN_AXES]);
                     end
                     state_ff <= ST_MUL;
                  end else begin
                     if (busy_ff) begin
                        for (int i = 0; i < IN_AXES; i++)
                           act_ff[i] <= (i < AXES) ? lane_act[i % AXES] : ACT_NONE;
                        count_ff <= count_nx;
                        if (count_nx >= total_ff) busy_ff <= 1'b0;
                        done_ff <= (count_nx >= total_ff);
                        moving_ff <= count_nx < total_ff;
                     end else begin
                        for (int i = 0; i < IN_AXES; i++) act_ff[i] <= ACT_NONE;
                        done_ff <= 1'b0;
                        moving_ff <= 1'b0;
                     end
                     state_ff <= ST_RESP;
                  end
               end
            end
            ST_MUL: begin
               total_ff <= TICK_W'(dur_ff) * TICK_W'(rate_ff);
               ax_ff    <= '0;
               state_ff <= ST_DIVST;
            end
            ST_DIVST: begin
               busy_ff   <= (total_ff != '0);
               moving_ff <= (total_ff != '0);
               divr_ff   <= DIVR_W'(mag_ff[ax_ff]) * DIVR_W'(scale_eff);
               if (mag_ff[ax_ff] == '0 || divr_ff == '0) begin
                  if (divr_ff != '0 || mag_ff[ax_ff] == '0) begin
                     if (ax_ff == AX_W'(AXES - 1)) state_ff <= ST_RESP;
                     else ax_ff <= ax_ff + 1'b1;
                  end
               end else begin
                  state_ff <= ST_DIVWT;
               end
            end
            ST_DIVWT: begin
               if (drsp.done) begin
                  divr_ff <= '0;
                  if (ax_ff == AX_W'(AXES - 1)) state_ff <= ST_RESP;
                  else begin
                     ax_ff    <= ax_ff + 1'b1;
                     state_ff <= ST_DIVST;
                  end
               end
            end
            ST_RESP: begin
               rvalid_ff <= 1'b1;
               state_ff  <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp.valid     = rvalid_ff;
   assign rsp.action_x  = act_ff[0];
   assign rsp.action_y  = act_ff[1];
   assign rsp.action_z  = act_ff[2];
   assign rsp.moving    = moving_ff;
   assign rsp.move_done = done_ff;

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.move_done |-> !rsp.moving)
      else $error("move_done with moving set");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rvalid_ff |-> !req.ready)
      else $error("accept while response pending");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      busy_ff && state_ff == ST_IDLE |-> count_ff < total_ff)
      else $error("tick count past total");
endmodule
